// ----- rtl/swsfr_pkg.sv -----
// Shared types and constants for the sliding window sender.
`default_nettype none

package swsfr_pkg;

  // Fixed port widths
  localparam int CMD_W  = 2;
  localparam int SEQ_W  = 3;
  localparam int DATA_W = 64;
  localparam int WIN_W  = 3;

  // Window size after reset
  localparam logic [WIN_W-1:0] WIN_RESET = 3'd4;

  // Duplicate acknowledgment count that triggers a fast retransmit
  localparam logic [1:0] DUP_FAST = 2'd3;
  localparam logic [1:0] DUP_FIRST = 2'd1;
  localparam logic [1:0] DUP_CLEAR = 2'd0;

  typedef enum logic [CMD_W-1:0] {
    CMD_SEND    = 2'd0,
    CMD_ACK     = 2'd1,
    CMD_TIMEOUT = 2'd2,
    CMD_NONE    = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    TMR_NONE    = 2'd0,
    TMR_START   = 2'd1,
    TMR_STOP    = 2'd2,
    TMR_RESTART = 2'd3
  } tmr_act_t;

endpackage

`default_nettype wire

// ----- rtl/swsfr_step.sv -----
// Next-state and result logic for one request of the sliding window sender.
`default_nettype none

module swsfr_step #(
  parameter int SB = 3
) (
  input  swsfr_pkg::cmd_t                  cmd,
  input  logic [SB-1:0]                    ack,
  input  logic                             ok,
  input  logic [swsfr_pkg::WIN_W-1:0]      win_size,
  input  logic [SB-1:0]                    base,
  input  logic [SB-1:0]                    nseq,
  input  logic                             full,
  input  logic                             trun,
  input  logic [SB-1:0]                    ttag,
  input  logic                             lav,
  input  logic [SB-1:0]                    las,
  input  logic [1:0]                       dup,
  output logic [SB-1:0]                    base_nxt,
  output logic [SB-1:0]                    nseq_nxt,
  output logic                             full_nxt,
  output logic                             trun_nxt,
  output logic [SB-1:0]                    ttag_nxt,
  output logic                             lav_nxt,
  output logic [SB-1:0]                    las_nxt,
  output logic [1:0]                       dup_nxt,
  output logic                             store_we,
  output logic                             accepted,
  output logic                             tx_valid,
  output logic                             tx_from_store,
  output logic [SB-1:0]                    tx_seq,
  output swsfr_pkg::tmr_act_t              tmr_act,
  output logic [SB-1:0]                    stop_seq,
  output logic [SB-1:0]                    start_seq
);
  import swsfr_pkg::*;

  // Common compare width for outstanding count versus window size
  localparam int CW = (SB > WIN_W) ? SB : WIN_W;

  logic [SB-1:0] seq_inc;
  logic [SB-1:0] ack_inc;
  logic [SB-1:0] out_send;
  logic [SB-1:0] out_ack;
  logic [SB-1:0] out_now;
  logic [CW-1:0] out_send_w;
  logic [CW-1:0] out_ack_w;
  logic [CW-1:0] out_now_w;
  logic [CW-1:0] win_w;
  logic          ack_new;
  logic [1:0]    dup_cnt;

  // Window arithmetic
  assign seq_inc    = nseq + SB'(1);
  assign ack_inc    = ack + SB'(1);
  assign out_send   = seq_inc - base;
  assign out_ack    = nseq - ack_inc;
  assign out_now    = nseq - base;
  assign out_send_w = CW'(out_send);
  assign out_ack_w  = CW'(out_ack);
  assign out_now_w  = CW'(out_now);
  assign win_w      = CW'(win_size);

  // Count repeats of the last acknowledgment number
  assign ack_new = !lav || (las != ack);
  assign dup_cnt = ack_new ? DUP_FIRST : dup + 2'd1;

  always_comb begin
    base_nxt      = base;
    nseq_nxt      = nseq;
    full_nxt      = full;
    trun_nxt      = trun;
    ttag_nxt      = ttag;
    lav_nxt       = lav;
    las_nxt       = las;
    dup_nxt       = dup;
    store_we      = 1'b0;
    accepted      = 1'b0;
    tx_valid      = 1'b0;
    tx_from_store = 1'b0;
    tx_seq        = '0;
    tmr_act       = TMR_NONE;
    stop_seq      = '0;
    start_seq     = '0;
    unique case (cmd)
      CMD_SEND: begin
        if (!full) begin
          store_we = 1'b1;
          accepted = 1'b1;
          tx_valid = 1'b1;
          tx_seq   = nseq;
          nseq_nxt = seq_inc;
          if (out_send_w == win_w) begin
            full_nxt = 1'b1;
          end
          if (!trun) begin
            tmr_act   = TMR_START;
            start_seq = base;
            ttag_nxt  = base;
            trun_nxt  = 1'b1;
          end
        end
      end
      CMD_ACK: begin
        if (ok) begin
          lav_nxt = 1'b1;
          las_nxt = ack;
          if (dup_cnt == DUP_FAST) begin
            // Fast retransmit at base and restart the timer, or start it if it is not running
            dup_nxt       = DUP_CLEAR;
            tx_valid      = 1'b1;
            tx_from_store = 1'b1;
            tx_seq        = base;
            tmr_act       = trun ? TMR_RESTART : TMR_START;
            stop_seq      = trun ? ttag : '0;
            start_seq     = base;
            ttag_nxt      = base;
            trun_nxt      = 1'b1;
            if (out_now_w < win_w) begin
              full_nxt = 1'b0;
            end
          end else begin
            // Slide the window past the acknowledged number
            dup_nxt  = dup_cnt;
            base_nxt = ack_inc;
            stop_seq = ttag;
            if (ack_inc != nseq) begin
              tmr_act   = TMR_RESTART;
              start_seq = ack_inc;
              ttag_nxt  = ack_inc;
              trun_nxt  = 1'b1;
            end else begin
              tmr_act  = TMR_STOP;
              trun_nxt = 1'b0;
            end
            if (out_ack_w < win_w) begin
              full_nxt = 1'b0;
            end
          end
        end
      end
      CMD_TIMEOUT: begin
        tx_valid      = 1'b1;
        tx_from_store = 1'b1;
        tx_seq        = base;
        tmr_act       = trun ? TMR_RESTART : TMR_START;
        stop_seq      = trun ? ttag : '0;
        start_seq     = base;
        ttag_nxt      = base;
        trun_nxt      = 1'b1;
      end
      CMD_NONE: begin
      end
      default: begin
      end
    endcase
  end

endmodule

`default_nettype wire

// ----- rtl/sliding_window_sender_fast_retransmit.sv -----
// Go-back-N sender with fast retransmit: window, timer control and payload store.
// A request accepted into the input register has its result loaded into the
// output register when it advances; a stall at the output holds it there.
// Throughput: one request per cycle while the output is not stalled; the payload
// store port has one write and one registered read at the window base.
// Reset clears all control state; the payload store is not cleared.
`default_nettype none

module sliding_window_sender_fast_retransmit #(
  parameter int SEQ_BITS     = 3,
  parameter int PAYLOAD_BITS = 64
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_wr_en,
  input  logic [swsfr_pkg::WIN_W-1:0]       cfg_wr_data,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [swsfr_pkg::CMD_W-1:0]       in_command,
  input  logic [swsfr_pkg::DATA_W-1:0]      in_payload,
  input  logic [swsfr_pkg::SEQ_W-1:0]       in_ack_number,
  input  logic                              in_checksum_ok,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic                              out_accepted,
  output logic                              out_transmit_valid,
  output logic [swsfr_pkg::SEQ_W-1:0]       out_transmit_seq,
  output logic [swsfr_pkg::DATA_W-1:0]      out_transmit_data,
  output logic [1:0]                        out_timer_action,
  output logic [swsfr_pkg::SEQ_W-1:0]       out_stop_seq,
  output logic [swsfr_pkg::SEQ_W-1:0]       out_start_seq,
  output logic                              out_window_full
);
  import swsfr_pkg::*;

  localparam int SB    = SEQ_BITS;
  localparam int PB    = PAYLOAD_BITS;
  localparam int DEPTH = 1 << SB;

  // Configuration
  logic [WIN_W-1:0] win_size_r;

  // Input register
  logic          s1_vld_r;
  cmd_t          s1_cmd_r;
  logic [PB-1:0] s1_data_r;
  logic [SB-1:0] s1_ack_r;
  logic          s1_ok_r;

  // Sender state
  logic [SB-1:0] base_r, base_nxt;
  logic [SB-1:0] nseq_r, nseq_nxt;
  logic          full_r, full_nxt;
  logic          trun_r, trun_nxt;
  logic [SB-1:0] ttag_r, ttag_nxt;
  logic          lav_r, lav_nxt;
  logic [SB-1:0] las_r, las_nxt;
  logic [1:0]    dup_r, dup_nxt;

  // Payload store
  logic [PB-1:0] store_mem [DEPTH];

  // Step results
  logic          store_we;
  logic          st_accepted;
  logic          st_tx_valid;
  logic          st_from_store;
  logic [SB-1:0] st_tx_seq;
  tmr_act_t      st_tmr_act;
  logic [SB-1:0] st_stop_seq;
  logic [SB-1:0] st_start_seq;

  // Output register
  logic          out_vld_r;
  logic          acc_r;
  logic          txv_r;
  logic [SB-1:0] txs_r;
  logic [PB-1:0] txd_r;
  tmr_act_t      tact_r;
  logic [SB-1:0] stop_r;
  logic [SB-1:0] start_r;
  logic          wfull_r;

  // Width conversion helpers
  logic [SB+SEQ_W-1:0]    ack_ext;
  logic [PB+DATA_W-1:0]   pay_ext;
  logic [SB+SEQ_W-1:0]    txs_ext;
  logic [SB+SEQ_W-1:0]    stop_ext;
  logic [SB+SEQ_W-1:0]    start_ext;
  logic [PB+DATA_W-1:0]   txd_ext;

  logic in_acc;
  logic adv;

  // Handshake: advance when the output register is free or draining
  assign adv      = s1_vld_r && (!out_vld_r || !out_stall);
  assign in_stall = s1_vld_r && !adv;
  assign in_acc   = in_valid && !in_stall;

  assign ack_ext = {{SB{1'b0}}, in_ack_number};
  assign pay_ext = {{PB{1'b0}}, in_payload};

  // Hold the window size register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_size_r <= WIN_RESET;
    end else if (cfg_wr_en) begin
      win_size_r <= cfg_wr_data;
    end
  end

  // Capture the request
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else if (in_acc) begin
      s1_vld_r <= 1'b1;
    end else if (adv) begin
      s1_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_cmd_r  <= cmd_t'(in_command);
      s1_data_r <= pay_ext[PB-1:0];
      s1_ack_r  <= ack_ext[SB-1:0];
      s1_ok_r   <= in_checksum_ok;
    end
  end

  swsfr_step #(
    .SB (SB)
  ) u_step (
    .cmd           (s1_cmd_r),
    .ack           (s1_ack_r),
    .ok            (s1_ok_r),
    .win_size      (win_size_r),
    .base          (base_r),
    .nseq          (nseq_r),
    .full          (full_r),
    .trun          (trun_r),
    .ttag          (ttag_r),
    .lav           (lav_r),
    .las           (las_r),
    .dup           (dup_r),
    .base_nxt      (base_nxt),
    .nseq_nxt      (nseq_nxt),
    .full_nxt      (full_nxt),
    .trun_nxt      (trun_nxt),
    .ttag_nxt      (ttag_nxt),
    .lav_nxt       (lav_nxt),
    .las_nxt       (las_nxt),
    .dup_nxt       (dup_nxt),
    .store_we      (store_we),
    .accepted      (st_accepted),
    .tx_valid      (st_tx_valid),
    .tx_from_store (st_from_store),
    .tx_seq        (st_tx_seq),
    .tmr_act       (st_tmr_act),
    .stop_seq      (st_stop_seq),
    .start_seq     (st_start_seq)
  );

  // Update sender state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_r <= '0;
      nseq_r <= '0;
      full_r <= 1'b0;
      trun_r <= 1'b0;
      ttag_r <= '0;
      lav_r  <= 1'b0;
      las_r  <= '0;
      dup_r  <= '0;
    end else if (adv) begin
      base_r <= base_nxt;
      nseq_r <= nseq_nxt;
      full_r <= full_nxt;
      trun_r <= trun_nxt;
      ttag_r <= ttag_nxt;
      lav_r  <= lav_nxt;
      las_r  <= las_nxt;
      dup_r  <= dup_nxt;
    end
  end

  // Write the payload of an accepted send
  always_ff @(posedge clk) begin
    if (adv && store_we) begin
      store_mem[nseq_r] <= s1_data_r;
    end
  end

  // Load the result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (adv) begin
      out_vld_r <= 1'b1;
    end else if (!out_stall) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      acc_r   <= st_accepted;
      txv_r   <= st_tx_valid;
      txs_r   <= st_tx_seq;
      tact_r  <= st_tmr_act;
      stop_r  <= st_stop_seq;
      start_r <= st_start_seq;
      wfull_r <= full_nxt;
      if (st_from_store) begin
        txd_r <= store_mem[base_r];
      end else if (st_tx_valid) begin
        txd_r <= s1_data_r;
      end else begin
        txd_r <= '0;
      end
    end
  end

  // Drive the result ports
  assign txs_ext   = {{SEQ_W{1'b0}}, txs_r};
  assign stop_ext  = {{SEQ_W{1'b0}}, stop_r};
  assign start_ext = {{SEQ_W{1'b0}}, start_r};
  assign txd_ext   = {{DATA_W{1'b0}}, txd_r};

  assign out_valid          = out_vld_r;
  assign out_accepted       = acc_r;
  assign out_transmit_valid = txv_r;
  assign out_transmit_seq   = txs_ext[SEQ_W-1:0];
  assign out_transmit_data  = txd_ext[DATA_W-1:0];
  assign out_timer_action   = tact_r;
  assign out_stop_seq       = stop_ext[SEQ_W-1:0];
  assign out_start_seq      = start_ext[SEQ_W-1:0];
  assign out_window_full    = wfull_r;

endmodule

`default_nettype wire
